### design/pac_pkg.sv
// Package for the periodic autocorrelation checker.
// Holds the sequence geometry, field widths, register map and shared types.
// No dependencies; every other design file imports it.
`default_nettype none

package pac_pkg;

	// Sequence geometry
	localparam int SEQ_LEN    = 34;
	localparam int SIGN_BITS  = 32;
	localparam int NUM_SHIFTS = SEQ_LEN - 1;
	// Entry 0 is zero, so every nonzero shift keeps this many +-1 products
	localparam int PAIRS      = SEQ_LEN - 2;

	// Popcount chunking of the per-shift mismatch vectors
	localparam int CHUNK       = 8;
	localparam int NCHUNK      = (SEQ_LEN + CHUNK - 1) / CHUNK;
	localparam int CHUNK_CNT_W = $clog2(CHUNK + 1);
	localparam int MISMATCH_W  = $clog2(PAIRS + 1);

	// Field widths
	localparam int BOUND_W     = 6;
	localparam int SHIFT_W     = 6;
	localparam int VALUE_W     = 7;
	localparam int OUT_FIELD_W = 1 + SHIFT_W + VALUE_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// Register map
	localparam int ADDR_W    = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CORR_BOUND = 1'b0;
	localparam logic [BOUND_W-1:0] CORR_BOUND_RESET = BOUND_W'(2);

	typedef logic [CHUNK_CNT_W-1:0] chunk_cnt_t;
	typedef chunk_cnt_t [NCHUNK-1:0] shift_cnt_t;
	typedef shift_cnt_t [NUM_SHIFTS-1:0] cnt_bank_t;
	typedef logic [VALUE_W-1:0] corr_t;
	typedef corr_t [NUM_SHIFTS-1:0] corr_bank_t;

	// Count set bits of one chunk
	function automatic chunk_cnt_t popcount_chunk(input logic [CHUNK-1:0] v);
		chunk_cnt_t c;
		c = '0;
		for (int i = 0; i < CHUNK; i++) begin
			c = c + chunk_cnt_t'(v[i]);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### design/pac_xor_count.sv
// Stage 2: per-shift sign mismatch vectors and chunked popcounts.
// Depends on pac_pkg.
`default_nettype none

module pac_xor_count
	import pac_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [SIGN_BITS-1:0] signs_s1,
	output cnt_bank_t                 cnt_s2
);

	logic [SEQ_LEN-1:0] neg;
	logic [NCHUNK*CHUNK-1:0] mism [NUM_SHIFTS];
	cnt_bank_t cnt_d;

	// Expand sign bits: entries 0 and 1 and entries past the input are not negative
	always_comb begin
		neg = '0;
		for (int k = 2; k < SEQ_LEN; k++) begin
			if (k - 2 < SIGN_BITS) begin
				neg[k] = signs_s1[k-2];
			end
		end
	end

	// Mark disagreeing pairs; pairs that touch entry 0 contribute nothing
	always_comb begin
		int k;
		for (int s = 1; s <= NUM_SHIFTS; s++) begin
			mism[s-1] = '0;
			for (int j = 0; j < SEQ_LEN; j++) begin
				k = j + s;
				if (k >= SEQ_LEN) begin
					k = k - SEQ_LEN;
				end
				if (j != 0 && k != 0) begin
					mism[s-1][j] = neg[j] ^ neg[k];
				end
			end
		end
	end

	// Count mismatches per chunk
	always_comb begin
		for (int s = 0; s < NUM_SHIFTS; s++) begin
			for (int c = 0; c < NCHUNK; c++) begin
				cnt_d[s][c] = popcount_chunk(mism[s][c*CHUNK +: CHUNK]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s2 <= cnt_d;
		end
	end

endmodule

`default_nettype wire

### design/pac_corr_eval.sv
// Stage 3: correlation value and bound check for every shift.
// Depends on pac_pkg.
`default_nettype none

module pac_corr_eval
	import pac_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [BOUND_W-1:0] bound,
	input  wire cnt_bank_t          cnt_s2,
	output corr_bank_t              corr_s3,
	output logic [NUM_SHIFTS-1:0]   bad_s3
);

	corr_bank_t corr_d;
	logic [NUM_SHIFTS-1:0] bad_d;

	// C = PAIRS - 2 * mismatches; flag magnitudes above the bound
	always_comb begin
		logic [MISMATCH_W-1:0] d;
		logic signed [VALUE_W:0] diff;
		logic [VALUE_W:0] mag;
		for (int s = 0; s < NUM_SHIFTS; s++) begin
			d = '0;
			for (int c = 0; c < NCHUNK; c++) begin
				d = d + MISMATCH_W'(cnt_s2[s][c]);
			end
			diff = $signed((VALUE_W+1)'(PAIRS)) - $signed((VALUE_W+1)'({d, 1'b0}));
			mag = diff[VALUE_W] ? 
				(VALUE_W+1)'(-diff) : (VALUE_W+1)'(diff);
			bad_d[s] = mag > (VALUE_W+1)'(bound);
			corr_d[s] = diff[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corr_s3 <= corr_d;
			bad_s3 <= bad_d;
		end
	end

endmodule

`default_nettype wire

### design/pac_first_bad.sv
// Stage 4: pick the smallest failing shift and its correlation.
// Depends on pac_pkg; registers feed the output channel directly.
`default_nettype none

module pac_first_bad
	import pac_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire corr_bank_t           corr_s3,
	input  wire logic [NUM_SHIFTS-1:0] bad_s3,
	output logic                      good_s4,
	output logic [SHIFT_W-1:0]        shift_s4,
	output logic [VALUE_W-1:0]        value_s4
);

	logic [SHIFT_W-1:0] shift_d;
	corr_t value_d;

	// Priority select, lowest shift wins
	always_comb begin
		shift_d = '0;
		value_d = '0;
		for (int s = NUM_SHIFTS - 1; s >= 0; s--) begin
			if (bad_s3[s]) begin
				shift_d = SHIFT_W'(s + 1);
				value_d = corr_s3[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			good_s4 <= ~|bad_s3;
			shift_s4 <= shift_d;
			value_s4 <= value_d;
		end
	end

endmodule

`default_nettype wire

### design/periodic_autocorrelation_checker.sv
// Periodic autocorrelation checker, top level.
// Depends on pac_pkg, pac_xor_count, pac_corr_eval, pac_first_bad.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one candidate per
//   transaction: s_tdata holds the 32 sign bits of entries 2 and up.
//   Master stream (m_tvalid/m_tready/m_tdata) returns one result per
//   candidate, in order: good, first failing shift and its correlation.
//   The APB port holds corr_bound at address 0 (reset value 2).
//   Pipeline: four register stages, namely input capture, mismatch
//   popcount, correlation and bound check, and first-failure select into
//   the output register. Throughput: one candidate per cycle while the
//   receiver accepts results; a stall holds the flow as described below.
//   Reset clears all stage valid bits and restores corr_bound.
//   When the receiver stalls, stages fill up behind the output register;
//   each stage holds its transaction until the next one frees, and
//   s_tready drops only once every stage holds a result.
`default_nettype none

module periodic_autocorrelation_checker
	import pac_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// APB configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]       prdata,
	output logic                        pready,
	// Candidate stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [SIGN_BITS-1:0]   s_tdata,  // [31:0] candidate_signs
	// Result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [0] good, [6:1] first_bad_shift, [13:7] bad_value, [15:14] zero
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	logic [BOUND_W-1:0] corr_bound_q;
	logic [SIGN_BITS-1:0] signs_s1;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;
	cnt_bank_t cnt_s2;
	corr_bank_t corr_s3;
	logic [NUM_SHIFTS-1:0] bad_s3;
	logic good_s4;
	logic [SHIFT_W-1:0] shift_s4;
	logic [VALUE_W-1:0] value_s4;
	logic reg_sel;

	// Configuration register
	assign pready = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_bound_q <= CORR_BOUND_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_CORR_BOUND) begin
			corr_bound_q <= pwdata[BOUND_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_CORR_BOUND) begin
			prdata = APB_DATA_W'(corr_bound_q);
		end
	end

	// Stage advance: a stage moves when empty or when the next one moves
	assign en4 = !valid_s4 || m_tready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= s_tvalid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Capture candidate
	always_ff @(posedge clk) begin
		if (en1) begin
			signs_s1 <= s_tdata;
		end
	end

	pac_xor_count u_xor_count (
		.clk      (clk),
		.en       (en2),
		.signs_s1 (signs_s1),
		.cnt_s2   (cnt_s2)
	);

	pac_corr_eval u_corr_eval (
		.clk     (clk),
		.en      (en3),
		.bound   (corr_bound_q),
		.cnt_s2  (cnt_s2),
		.corr_s3 (corr_s3),
		.bad_s3  (bad_s3)
	);

	pac_first_bad u_first_bad (
		.clk      (clk),
		.en       (en4),
		.corr_s3  (corr_s3),
		.bad_s3   (bad_s3),
		.good_s4  (good_s4),
		.shift_s4 (shift_s4),
		.value_s4 (value_s4)
	);

	// Drive result transaction
	assign m_tvalid = valid_s4;
	assign m_tdata = OUT_TDATA_W'({value_s4, shift_s4, good_s4});

endmodule

`default_nettype wire
